@@ design/tspc_pkg.sv @@
package tspc_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_TEST  = 3'd1,
		MODE_LINK  = 3'd2,
		MODE_WAIT  = 3'd3,
		MODE_REPLY = 3'd4
	} mode_t;

	localparam logic [1:0] ACT_POLL  = 2'd0;
	localparam logic [1:0] ACT_NET   = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	localparam logic [2:0] REG_MAX_DRIFT       = 3'd0;
	localparam logic [2:0] REG_MIN_POLL        = 3'd1;
	localparam logic [2:0] REG_MAX_POLL        = 3'd2;
	localparam logic [2:0] REG_POLL_STEP       = 3'd3;
	localparam logic [2:0] REG_INITIAL_POLL    = 3'd4;
	localparam logic [2:0] REG_REQUEST_RETRIES = 3'd5;
	localparam logic [2:0] REG_REPLY_TIMEOUT   = 3'd6;
	localparam logic [2:0] REG_RTC_TEST_MS     = 3'd7;

	localparam logic [31:0] DRIFT_PERIOD   = 32'd600;
	localparam logic [31:0] SYNC_TOLERANCE = 32'd60;
	localparam logic [31:0] SET_THRESHOLD  = 32'd1;
	localparam logic [19:0] INTERVAL_MAX   = 20'hFFFFF;
	localparam logic [19:0] INIT_INTERVAL  = 20'd3600;
	localparam logic [15:0] BAD_MAX        = 16'hFFFF;

	typedef struct packed {
		logic [15:0] max_drift;
		logic [19:0] min_poll_interval;
		logic [19:0] max_poll_interval;
		logic [15:0] poll_step;
		logic [7:0]  request_retries;
		logic [7:0]  reply_timeout;
		logic [15:0] rtc_test_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_sec;
		logic [31:0] now_ms;
		logic [31:0] rtc_time;
		logic        rtc_detected;
		logic        link_up;
		logic        reply_valid;
		logic [31:0] reply_time;
	} item_t;

	typedef struct packed {
		mode_t              sync_state;
		logic [1:0]         requests_sent;
		logic               open_socket;
		logic               set_system;
		logic               set_rtc;
		logic [31:0]        new_time;
		logic [19:0]        poll_interval;
		logic               rtc_present;
		logic signed [31:0] rtc_drift;
		logic [15:0]        bad_readings;
	} res_t;

endpackage

@@ design/tspc_cfg_regs.sv @@
module tspc_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	output tspc_pkg::cfg_t   cfg
);
	import tspc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg     = cfg_q;

	// the initial interval only matters at reset, so a write to it is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_drift         <= 16'd5;
			cfg_q.min_poll_interval <= 20'd60;
			cfg_q.max_poll_interval <= 20'd86400;
			cfg_q.poll_step         <= 16'd60;
			cfg_q.request_retries   <= 8'd3;
			cfg_q.reply_timeout     <= 8'd5;
			cfg_q.rtc_test_ms       <= 16'd2000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_DRIFT:       cfg_q.max_drift         <= cfg_data[15:0];
				REG_MIN_POLL:        cfg_q.min_poll_interval <= cfg_data[19:0];
				REG_MAX_POLL:        cfg_q.max_poll_interval <= cfg_data[19:0];
				REG_POLL_STEP:       cfg_q.poll_step         <= cfg_data[15:0];
				REG_REQUEST_RETRIES: cfg_q.request_retries   <= cfg_data[7:0];
				REG_REPLY_TIMEOUT:   cfg_q.reply_timeout     <= cfg_data[7:0];
				REG_RTC_TEST_MS:     cfg_q.rtc_test_ms       <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ design/tspc_engine.sv @@
module tspc_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tspc_pkg::item_t item,
	input  tspc_pkg::cfg_t  cfg,
	output tspc_pkg::res_t  res
);
	import tspc_pkg::*;

	function automatic logic [31:0] mag32(input logic [31:0] d);
		mag32 = d[31] ? (32'd0 - d) : d;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	mode_t       mode_q, mode_d;
	logic        rtc_ok_q, rtc_ok_d;
	logic [31:0] rtc_start_q, rtc_start_d;
	logic [31:0] test_deadline_q, test_deadline_d;
	logic [31:0] next_req_q, next_req_d;
	logic [31:0] last_check_q, last_check_d;
	logic [31:0] reply_deadline_q, reply_deadline_d;
	logic [7:0]  retries_q, retries_d;
	logic [31:0] prev_rtc_q, prev_rtc_d;
	logic [19:0] interval_q, interval_d;
	logic [31:0] drift_q, drift_d;
	logic [15:0] bad_q, bad_d;

	logic is_start, is_net, is_poll;
	logic in_test, in_link, in_wait, in_reply;

	// time update, shared by start and server reply
	logic        upd_en;
	logic [31:0] upd_nt, upd_after;
	logic        upd_rtc_ok, upd_setsys, upd_setrtc;
	logic [31:0] d_sys, d_rtc;
	logic [19:0] upd_interval;
	logic [20:0] grown;

	logic [31:0] ms_diff;
	logic        test_pass, test_fail;
	logic        net_down, link_send;
	logic [32:0] check_due_at;
	logic        drift_due, drift_big, drift_back, drift_send, bad_inc, due_send;
	logic [31:0] drift_new;
	logic        reply_tmo, retry, wait_enter, send_any;
	logic [31:0] wait_sys;
	logic [19:0] wait_int;

	assign is_start = (item.action == ACT_START);
	assign is_net   = (item.action == ACT_NET);
	assign is_poll  = (item.action == ACT_POLL);
	assign in_test  = (mode_q == MODE_TEST);
	assign in_link  = (mode_q == MODE_LINK);
	assign in_wait  = (mode_q == MODE_WAIT);
	assign in_reply = (mode_q == MODE_REPLY);

	always_comb begin
		upd_nt     = is_start ? item.rtc_time : item.reply_time;
		upd_rtc_ok = is_start ? item.rtc_detected : rtc_ok_q;
		d_sys      = mag32(item.now_sec - upd_nt);
		d_rtc      = mag32(item.rtc_time - upd_nt);
		upd_setsys = (d_sys > SET_THRESHOLD);
		upd_setrtc = upd_rtc_ok && (d_rtc > SET_THRESHOLD);
		upd_after  = upd_setsys ? upd_nt : item.now_sec;
		grown      = {1'b0, interval_q} + {4'b0, cfg.poll_step, 1'b0};
		upd_interval = interval_q;
		if (d_sys > {16'b0, cfg.max_drift}) begin
			if (cfg.min_poll_interval < interval_q) begin
				upd_interval = (interval_q > {4'b0, cfg.poll_step}) ?
					interval_q - {4'b0, cfg.poll_step} : 20'd0;
			end
		end else if (cfg.max_poll_interval > interval_q) begin
			upd_interval = grown[20] ? INTERVAL_MAX : grown[19:0];
		end
	end

	assign upd_en = (is_start && item.rtc_detected) ||
		(is_poll && in_reply && item.reply_valid);

	assign ms_diff   = item.now_ms - test_deadline_q;
	assign test_pass = is_poll && in_test && rtc_ok_q && (item.rtc_time > rtc_start_q);
	assign test_fail = is_poll && in_test && !test_pass &&
		(ms_diff != 32'd0) && !ms_diff[31];

	assign net_down  = is_net && (in_wait || in_reply) && !item.link_up;
	assign link_send = is_poll && in_link && item.link_up;

	assign check_due_at = {1'b0, last_check_q} + {1'b0, DRIFT_PERIOD};
	assign drift_due  = is_poll && in_wait && rtc_ok_q &&
		({1'b0, item.now_sec} >= check_due_at);
	assign drift_new  = item.rtc_time - item.now_sec;
	assign drift_big  = (mag32(drift_new) >= SYNC_TOLERANCE);
	assign drift_back = (item.rtc_time < prev_rtc_q);
	assign drift_send = drift_due && drift_big && !drift_back;
	assign bad_inc    = drift_due && drift_big && drift_back;
	assign due_send   = is_poll && in_wait && (item.now_sec > next_req_q);

	assign reply_tmo  = is_poll && in_reply && !item.reply_valid &&
		(item.now_sec >= reply_deadline_q);
	assign retry      = reply_tmo && (retries_q != 8'd0);
	assign wait_enter = (upd_en && !is_start) || (reply_tmo && (retries_q == 8'd0));
	assign send_any   = link_send || drift_send || due_send || retry;

	// after a reply, wait from the corrected system time and the new interval
	assign wait_sys = upd_en ? upd_after : item.now_sec;
	assign wait_int = upd_en ? upd_interval : interval_q;

	always_comb begin
		mode_d = mode_q;
		if (is_start) begin
			mode_d = MODE_TEST;
		end else if (net_down || test_pass || test_fail) begin
			mode_d = MODE_LINK;
		end else if (send_any) begin
			mode_d = MODE_REPLY;
		end else if (wait_enter) begin
			mode_d = MODE_WAIT;
		end
	end

	always_comb begin
		rtc_ok_d = rtc_ok_q;
		if (is_start) begin
			rtc_ok_d = item.rtc_detected;
		end else if (test_fail) begin
			rtc_ok_d = 1'b0;
		end
		rtc_start_d = rtc_start_q;
		test_deadline_d = test_deadline_q;
		if (is_start) begin
			rtc_start_d     = item.rtc_detected ? item.rtc_time : 32'd0;
			test_deadline_d = item.now_ms + {16'b0, cfg.rtc_test_ms};
		end
		next_req_d   = wait_enter ? sat_add(wait_sys, {12'b0, wait_int}) : next_req_q;
		last_check_d = wait_enter ? wait_sys : (drift_due ? item.now_sec : last_check_q);
		reply_deadline_d = send_any ?
			sat_add(item.now_sec, {24'b0, cfg.reply_timeout}) : reply_deadline_q;
		retries_d = retries_q;
		if (wait_enter) begin
			retries_d = cfg.request_retries;
		end else if (retry) begin
			retries_d = retries_q - 8'd1;
		end
		prev_rtc_d = (upd_en && upd_setrtc) ? upd_nt : prev_rtc_q;
		interval_d = upd_en ? upd_interval : interval_q;
		drift_d    = drift_due ? drift_new : drift_q;
		bad_d      = (bad_inc && (bad_q != BAD_MAX)) ? bad_q + 16'd1 : bad_q;

		res.sync_state    = mode_d;
		res.requests_sent = {1'b0, link_send} + {1'b0, drift_send} +
			{1'b0, due_send} + {1'b0, retry};
		res.open_socket   = link_send;
		res.set_system    = upd_en && upd_setsys;
		res.set_rtc       = upd_en && upd_setrtc;
		res.new_time      = (res.set_system || res.set_rtc) ? upd_nt : 32'd0;
		res.poll_interval = interval_d;
		res.rtc_present   = rtc_ok_d;
		res.rtc_drift     = drift_d;
		res.bad_readings  = bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_IDLE;
			rtc_ok_q         <= 1'b0;
			rtc_start_q      <= 32'd0;
			test_deadline_q  <= 32'd0;
			next_req_q       <= 32'd0;
			last_check_q     <= 32'd0;
			reply_deadline_q <= 32'd0;
			retries_q        <= 8'd0;
			prev_rtc_q       <= 32'd0;
			interval_q       <= INIT_INTERVAL;
			drift_q          <= 32'd0;
			bad_q            <= 16'd0;
		end else if (en) begin
			mode_q           <= mode_d;
			rtc_ok_q         <= rtc_ok_d;
			rtc_start_q      <= rtc_start_d;
			test_deadline_q  <= test_deadline_d;
			next_req_q       <= next_req_d;
			last_check_q     <= last_check_d;
			reply_deadline_q <= reply_deadline_d;
			retries_q        <= retries_d;
			prev_rtc_q       <= prev_rtc_d;
			interval_q       <= interval_d;
			drift_q          <= drift_d;
			bad_q            <= bad_d;
		end
	end

endmodule

@@ design/time_sync_poll_controller.sv @@
// Time synchronisation sequencer for a network time server with RTC backup.
// Input channel (in_valid / in_stall): one event per request - poll, network
// change or start - with the system seconds, millisecond counter, RTC
// reading, link state and any server reply. Output channel (out_valid /
// out_stall): exactly one result per event, carrying the mode after the
// event, request count, open-socket and set-time pulses, and status.
// Configuration (cfg_valid / cfg_ready, always ready) must be written by the
// user while idle; the block itself does not enforce this. The event is
// registered, evaluated combinationally against the sequencer state, and the
// result is registered. Throughput: one event per cycle when not stalled.
// Reset puts the sequencer in idle with an interval of 3600 s and the
// default register values; both channels come up empty.
// When the receiver stalls, the result register holds and the input stage
// still fills once; in_stall then rises until the result is taken.
module time_sync_poll_controller (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] now_sec,
	input  logic [31:0] now_ms,
	input  logic [31:0] rtc_time,
	input  logic        rtc_detected,
	input  logic        link_up,
	input  logic        reply_valid,
	input  logic [31:0] reply_time,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  sync_state,
	output logic [1:0]  requests_sent,
	output logic        open_socket,
	output logic        set_system,
	output logic        set_rtc,
	output logic [31:0] new_time,
	output logic [19:0] poll_interval,
	output logic        rtc_present,
	output logic signed [31:0] rtc_drift,
	output logic [15:0] bad_readings,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tspc_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_comb;
	res_t  res_q;
	logic  out_valid_q;
	logic  advance;
	logic  load_s1;

	tspc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tspc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	// move the staged request on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || advance) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.action       <= action;
			item_s1.now_sec      <= now_sec;
			item_s1.now_ms       <= now_ms;
			item_s1.rtc_time     <= rtc_time;
			item_s1.rtc_detected <= rtc_detected;
			item_s1.link_up      <= link_up;
			item_s1.reply_valid  <= reply_valid;
			item_s1.reply_time   <= reply_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign out_valid     = out_valid_q;
	assign sync_state    = res_q.sync_state;
	assign requests_sent = res_q.requests_sent;
	assign open_socket   = res_q.open_socket;
	assign set_system    = res_q.set_system;
	assign set_rtc       = res_q.set_rtc;
	assign new_time      = res_q.new_time;
	assign poll_interval = res_q.poll_interval;
	assign rtc_present   = res_q.rtc_present;
	assign rtc_drift     = res_q.rtc_drift;
	assign bad_readings  = res_q.bad_readings;

endmodule

@@ design/tspc_checker.sv @@
module tspc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  sync_state,
	input logic [1:0]  requests_sent,
	input logic        open_socket,
	input logic        set_system,
	input logic        set_rtc,
	input logic [31:0] new_time
);
	import tspc_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sync_state) && $stable(new_time))
		else $error("stalled result changed");

	// new_time carries a value only alongside a set pulse
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !set_system && !set_rtc |-> new_time == 32'd0)
		else $error("new_time without set pulse");

	// any request leaves the sequencer awaiting a reply
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && requests_sent != 2'd0 |-> sync_state == MODE_REPLY)
		else $error("request sent but not awaiting reply");

	// opening the socket comes with exactly one request and no time set
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && open_socket |-> requests_sent == 2'd1 && !set_system && !set_rtc)
		else $error("open socket without single request");

endmodule

bind time_sync_poll_controller tspc_checker u_tspc_checker (.*);
